// ----- hdl/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants of the base32 stream decoder
// word formats on both queue sides, the command passed from front to back,
// register map codes and count defaults
// ----------------------------------------------------------------------------
package b32d_pkg;

  // default saturation point of the decoded byte count
  localparam int unsigned CountMaxDefault = 32'd65535;

  // byte count register width
  localparam int unsigned CountW = 16;

  // pad character
  localparam logic [7:0] PadChar = 8'h3D;

  // depth of the internal queues
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes (address bit 2)
  localparam logic RegAlphabet = 1'b0;
  localparam logic RegPadding  = 1'b1;

  // input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        data_byte;
    logic              done_res;
    logic              status;
    logic [CountW-1:0] byte_count;
  } out_word_t;

  // classified character handed from front to back
  typedef struct packed {
    logic       sym_ok;
    logic [4:0] sym;
    logic       is_pad;
    logic       eot;
  } cmd_t;

endpackage

// ----- hdl/b32d_fifo.sv -----
// ----------------------------------------------------------------------------
// b32d_fifo: small synchronous queue
// register-file storage, push/pop with full and empty flags
// ----------------------------------------------------------------------------
module b32d_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/b32d_front.sv -----
// ----------------------------------------------------------------------------
// b32d_front: character classifier
// maps a character through the selected alphabet and flags the pad character
// ----------------------------------------------------------------------------
module b32d_front (
  input  b32d_pkg::in_word_t in_word_i,
  input  logic               alphabet_sel_i,
  output b32d_pkg::cmd_t     cmd_o
);
  import b32d_pkg::*;

  function automatic logic [5:0] lookup(input logic [7:0] c, input logic hex);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b0;
    if (hex) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        v = c - 8'h30; ok = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h56) begin
        v = c - 8'h41 + 8'd10; ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h76) begin
        v = c - 8'h61 + 8'd10; ok = 1'b1;
      end
    end else begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        v = c - 8'h41; ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        v = c - 8'h61; ok = 1'b1;
      end else if (c >= 8'h32 && c <= 8'h37) begin
        v = c - 8'h32 + 8'd26; ok = 1'b1;
      end
    end
    return {ok, v[4:0]};
  endfunction

  logic [5:0] lk;

  assign lk            = lookup(in_word_i.char_code, alphabet_sel_i);
  assign cmd_o.sym_ok  = lk[5];
  assign cmd_o.sym     = lk[4:0];
  assign cmd_o.is_pad  = (in_word_i.char_code == PadChar);
  assign cmd_o.eot     = in_word_i.end_of_text;

endmodule

// ----- hdl/b32d_back.sv -----
// ----------------------------------------------------------------------------
// b32d_back: symbol gatherer
// eight-phase bit packer, padding checker, error latch and byte counter
// ----------------------------------------------------------------------------
module b32d_back #(
  parameter int unsigned COUNT_MAX = b32d_pkg::CountMaxDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  b32d_pkg::cmd_t      cmd_i,
  input  logic                require_pad_i,
  output b32d_pkg::out_word_t res_o
);
  import b32d_pkg::*;

  localparam logic [CountW-1:0] CountLimit =
    (COUNT_MAX > 32'd65535) ? {CountW{1'b1}} : CountW'(COUNT_MAX);

  // pads that must follow a group stopping at a given phase
  function automatic logic [2:0] pad_need(input logic [2:0] ph);
    logic [2:0] n;
    unique case (ph)
      3'd2:    n = 3'd6;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd3;
      3'd7:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  logic [2:0]        phase_q, phase_d;
  logic [6:0]        left_q, left_d;
  logic              in_pad_q, in_pad_d;
  logic [2:0]        pads_req_q, pads_req_d;
  logic [2:0]        pads_seen_q, pads_seen_d;
  logic              failed_q, failed_d;
  logic [CountW-1:0] count_q, count_d;
  logic              valid;
  logic [7:0]        byte_v;
  logic [2:0]        need;
  logic [4:0]        v;

  assign v = cmd_i.sym;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    in_pad_d    = in_pad_q;
    pads_req_d  = pads_req_q;
    pads_seen_d = pads_seen_q;
    failed_d    = failed_q;
    count_d     = count_q;
    valid       = 1'b0;
    byte_v      = 8'd0;
    need        = pad_need(phase_q);

    if (!failed_q) begin
      if (in_pad_q) begin
        if (cmd_i.is_pad && pads_seen_q < pads_req_q) begin
          pads_seen_d = 3'(pads_seen_q + 3'd1);
        end else begin
          failed_d = 1'b1;
        end
      end else if (cmd_i.sym_ok) begin
        unique case (phase_q)
          3'd0: begin
            left_d = {2'b0, v}; phase_d = 3'd1;
          end
          3'd1: begin
            byte_v = {left_q[4:0], v[4:2]}; valid = 1'b1;
            left_d = {5'b0, v[1:0]}; phase_d = 3'd2;
          end
          3'd2: begin
            left_d = {left_q[1:0], v}; phase_d = 3'd3;
          end
          3'd3: begin
            byte_v = {left_q[6:0], v[4]}; valid = 1'b1;
            left_d = {3'b0, v[3:0]}; phase_d = 3'd4;
          end
          3'd4: begin
            byte_v = {left_q[3:0], v[4:1]}; valid = 1'b1;
            left_d = {6'b0, v[0]}; phase_d = 3'd5;
          end
          3'd5: begin
            left_d = {1'b0, left_q[0], v}; phase_d = 3'd6;
          end
          3'd6: begin
            byte_v = {left_q[5:0], v[4:3]}; valid = 1'b1;
            left_d = {4'b0, v[2:0]}; phase_d = 3'd7;
          end
          default: begin
            byte_v = {left_q[2:0], v}; valid = 1'b1;
            left_d = 7'd0; phase_d = 3'd0;
          end
        endcase
      end else if (require_pad_i && phase_q != 3'd0) begin
        if (need != 3'd0 && left_q == 7'd0 && cmd_i.is_pad) begin
          in_pad_d    = 1'b1;
          pads_req_d  = need;
          pads_seen_d = 3'd1;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        failed_d = 1'b1;
      end
    end

    if (valid && count_q < CountLimit) begin
      count_d = CountW'(count_q + 1'b1);
    end

    // end of text: incomplete padding or an open strict group fails
    if (cmd_i.eot && !failed_d) begin
      if (in_pad_d) begin
        if (pads_seen_d != pads_req_d) begin
          failed_d = 1'b1;
        end
      end else if (require_pad_i && phase_d != 3'd0) begin
        failed_d = 1'b1;
      end
    end

    res_o.byte_valid = valid;
    res_o.data_byte  = byte_v;
    res_o.done_res   = cmd_i.eot;
    res_o.status     = cmd_i.eot && failed_d;
    res_o.byte_count = count_d;

    if (cmd_i.eot) begin
      phase_d     = 3'd0;
      left_d      = 7'd0;
      in_pad_d    = 1'b0;
      pads_req_d  = 3'd0;
      pads_seen_d = 3'd0;
      failed_d    = 1'b0;
      count_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 3'd0;
      left_q      <= 7'd0;
      in_pad_q    <= 1'b0;
      pads_req_q  <= 3'd0;
      pads_seen_q <= 3'd0;
      failed_q    <= 1'b0;
      count_q     <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      in_pad_q    <= in_pad_d;
      pads_req_q  <= pads_req_d;
      pads_seen_q <= pads_seen_d;
      failed_q    <= failed_d;
      count_q     <= count_d;
    end
  end

endmodule

// ----- hdl/base32_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base32_stream_decoder: streaming base32 decoder, one character per word
// a pushed word is registered in the command queue, then its result in
// the result queue (empty falls); throughput: one word per cycle while
// the result queue has room, else the back end stalls
// reset: asynchronous active low; clears queues, decoder state and sets
// alphabet_select to 0 and require_padding to 1
// ----------------------------------------------------------------------------
module base32_stream_decoder #(
  parameter int unsigned COUNT_MAX = b32d_pkg::CountMaxDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input queue side
  input  logic                push,
  output logic                full,
  input  b32d_pkg::in_word_t  data_i,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output b32d_pkg::out_word_t data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import b32d_pkg::*;

  // configuration registers
  logic alph_q, alph_d;
  logic req_pad_q, req_pad_d;
  logic cfg_wr;

  // front to back command queue
  cmd_t cmd_in, cmd_head;
  logic cmd_full, cmd_empty;

  // back end result
  out_word_t res;
  logic      res_full;
  logic      fire;

  // ---------------------------------------------------------------------------
  // configuration port: no wait states, index from address bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    alph_d    = alph_q;
    req_pad_d = req_pad_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegAlphabet: alph_d    = pwdata[0];
        RegPadding:  req_pad_d = pwdata[0];
        default:     alph_d    = alph_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegAlphabet: prdata = {31'b0, alph_q};
      RegPadding:  prdata = {31'b0, req_pad_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q    <= 1'b0;
      req_pad_q <= 1'b1;
    end else begin
      alph_q    <= alph_d;
      req_pad_q <= req_pad_d;
    end
  end

  // ---------------------------------------------------------------------------
  // front end: classify the character as it is pushed
  // ---------------------------------------------------------------------------
  b32d_front u_front (
    .in_word_i      (data_i),
    .alphabet_sel_i (alph_q),
    .cmd_o          (cmd_in)
  );

  // the command queue is what the user sees as the input queue
  assign full = cmd_full;

  b32d_fifo #(
    .DEPTH (QueueDepth),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (fire),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  // ---------------------------------------------------------------------------
  // back end: one command per cycle whenever the result queue has room
  // ---------------------------------------------------------------------------
  assign fire = !cmd_empty && !res_full;

  b32d_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .cmd_i         (cmd_head),
    .require_pad_i (req_pad_q),
    .res_o         (res)
  );

  // result queue decouples the back end from the consumer
  b32d_fifo #(
    .DEPTH (QueueDepth),
    .WIDTH ($bits(out_word_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (data_o),
    .empty_o (empty)
  );

endmodule

// ----- hdl/b32d_checker.sv -----
// ----------------------------------------------------------------------------
// b32d_checker: port-level checks of the base32 stream decoder
// result word consistency and byte count ordering
// ----------------------------------------------------------------------------
module b32d_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input b32d_pkg::out_word_t data_o
);
  import b32d_pkg::*;

  // status only means something on the last word of a text
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.done_res) |-> !data_o.status)
    else $error("status set on a word that does not end a text");

  // no byte value without a byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.byte_valid) |-> (data_o.data_byte == 8'd0))
    else $error("data byte nonzero without byte valid");

  // within a text the count never falls
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !data_o.done_res) ##1 !empty
      |-> (data_o.byte_count >= $past(data_o.byte_count)))
    else $error("byte count fell within a text");

  // a new text starts counting from zero
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && data_o.done_res) ##1 !empty
      |-> (data_o.byte_count <= 16'd1))
    else $error("byte count not restarted after end of text");

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (.*);
